// ===== hdl/lpe_pkg.sv =====
package lpe_pkg;

    localparam int VALUE_W     = 32;
    localparam int RANGE_W     = 5;
    localparam int OUT_IDX_W   = 5;
    localparam int MAX_OUT     = 32;
    localparam int DEPTH_DEF   = 32;
    localparam int ELEM_W_DEF  = 32;

    typedef enum logic [3:0] {
        S_LOAD,
        S_CHECK,
        S_PIVOT,
        S_SCAN_RD,
        S_CMP,
        S_SWAP1,
        S_SWAP2,
        S_FIN_RD,
        S_FIN1,
        S_FIN2,
        S_EMIT_RD,
        S_EMIT_OUT
    } t_state;

endpackage

// ===== hdl/lpe_in_if.sv =====
interface lpe_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [lpe_pkg::VALUE_W-1:0] value;
    logic                               last;
    logic        [lpe_pkg::RANGE_W-1:0] range_low;
    logic        [lpe_pkg::RANGE_W-1:0] range_high;

    modport source (output valid, value, last, range_low, range_high, input ready);
    modport sink   (input valid, value, last, range_low, range_high, output ready);
endinterface

// ===== hdl/lpe_out_if.sv =====
interface lpe_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [lpe_pkg::OUT_IDX_W-1:0] index;
    logic signed [lpe_pkg::VALUE_W-1:0]   element;
    logic        [lpe_pkg::OUT_IDX_W-1:0] pivot_index;
    logic                                 bad_range;
    logic                                 final_res;

    modport source (output valid, index, element, pivot_index, bad_range, final_res,
                    input ready);
    modport sink   (input valid, index, element, pivot_index, bad_range, final_res,
                    output ready);
endinterface

// ===== hdl/lpe_mem.sv =====
module lpe_mem #(
    parameter int DEPTH = lpe_pkg::DEPTH_DEF,
    parameter int WIDTH = lpe_pkg::ELEM_W_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/lomuto_partition_engine.sv =====
// Load: one element per cycle, ready held high until the item marked last.
// Partition: pivot read, then per scanned element a read and a compare plus a
// two-step swap when needed, then the final pivot swap; an invalid range goes
// straight to emit. The one store read port and the one signed comparator set the pace.
// Emit: per result, a store read, then an output register load.
// Reset is synchronous, active low: sequencer, load count and output valid
// clear; the element store is not cleared.
module lomuto_partition_engine #(
    parameter int DEPTH         = lpe_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = lpe_pkg::ELEM_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpe_in_if.sink    i_in,
    lpe_out_if.source o_out
);
    import lpe_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > RANGE_W) ? CNT_W : RANGE_W;
    localparam int EXT_W = (ELEMENT_WIDTH > VALUE_W) ? ELEMENT_WIDTH : VALUE_W;

    t_state                     r_state, n_state;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [RANGE_W-1:0]         r_lo, n_lo;
    logic [RANGE_W-1:0]         r_hi, n_hi;
    logic [IDX_W-1:0]           r_bnd, n_bnd;
    logic [IDX_W-1:0]           r_scan, n_scan;
    logic [IDX_W-1:0]           r_piv, n_piv;
    logic [IDX_W-1:0]           r_k, n_k;
    logic                       r_bad, n_bad;
    logic [ELEMENT_WIDTH-1:0]   r_pivot, n_pivot;
    logic [ELEMENT_WIDTH-1:0]   r_sval, n_sval;

    logic                       r_ovalid, n_ovalid;
    logic [OUT_IDX_W-1:0]       r_oindex, n_oindex;
    logic [VALUE_W-1:0]         r_oelem, n_oelem;
    logic [OUT_IDX_W-1:0]       r_opiv, n_opiv;
    logic                       r_obad, n_obad;
    logic                       r_ofinal, n_ofinal;

    logic                       m_we;
    logic [IDX_W-1:0]           m_waddr;
    logic [ELEMENT_WIDTH-1:0]   m_wdata;
    logic [IDX_W-1:0]           m_raddr;
    logic [ELEMENT_WIDTH-1:0]   m_rdata;

    logic                       in_fire;
    logic [EXT_W-1:0]           val_ext;
    logic [EXT_W-1:0]           rd_ext;
    logic [CMP_W-1:0]           lo_x, hi_x, k_x, kp1_x, piv_x, cnt_x;
    logic [IDX_W-1:0]           lo_a, hi_a, scan_nxt;
    logic                       range_bad, less, scan_end, emit_last;

    lpe_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ELEMENT_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    assign i_in.ready = (r_state == S_LOAD);
    assign in_fire    = i_in.valid && (r_state == S_LOAD);

    // input word is sign-extended or cut to element width; output is zero-extended
    assign val_ext = EXT_W'(i_in.value);
    assign rd_ext  = EXT_W'(m_rdata);

    assign lo_x   = CMP_W'(r_lo);
    assign hi_x   = CMP_W'(r_hi);
    assign cnt_x  = CMP_W'(r_count);
    assign k_x    = CMP_W'(r_k);
    assign kp1_x  = k_x + 1'b1;
    assign piv_x  = CMP_W'(r_piv);
    assign lo_a   = lo_x[IDX_W-1:0];
    assign hi_a   = hi_x[IDX_W-1:0];

    assign range_bad = (r_lo > r_hi) || (hi_x >= cnt_x);
    assign less      = $signed(m_rdata) < $signed(r_pivot);
    assign scan_nxt  = r_scan + 1'b1;
    assign scan_end  = (scan_nxt == hi_a);
    assign emit_last = (kp1_x == cnt_x) || (k_x == CMP_W'(MAX_OUT - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_bnd    <= '0;
            r_scan   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_bnd    <= n_bnd;
            r_scan   <= n_scan;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_piv    <= n_piv;
        r_k      <= n_k;
        r_bad    <= n_bad;
        r_pivot  <= n_pivot;
        r_sval   <= n_sval;
        r_oindex <= n_oindex;
        r_oelem  <= n_oelem;
        r_opiv   <= n_opiv;
        r_obad   <= n_obad;
        r_ofinal <= n_ofinal;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_bnd    = r_bnd;
        n_scan   = r_scan;
        n_piv    = r_piv;
        n_k      = r_k;
        n_bad    = r_bad;
        n_pivot  = r_pivot;
        n_sval   = r_sval;
        n_ovalid = r_ovalid && !o_out.ready;
        n_oindex = r_oindex;
        n_oelem  = r_oelem;
        n_opiv   = r_opiv;
        n_obad   = r_obad;
        n_ofinal = r_ofinal;
        m_we     = 1'b0;
        m_waddr  = r_count[IDX_W-1:0];
        m_wdata  = val_ext[ELEMENT_WIDTH-1:0];
        m_raddr  = '0;

        case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    // a full store drops the value
                    if (r_count < CNT_W'(DEPTH)) begin
                        m_we    = 1'b1;
                        n_count = r_count + 1'b1;
                    end
                    if (i_in.last) begin
                        n_lo    = i_in.range_low;
                        n_hi    = i_in.range_high;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                n_k   = '0;
                n_piv = '0;
                n_bad = range_bad;
                if (range_bad) begin
                    n_state = S_EMIT_RD;
                end else begin
                    m_raddr = hi_a;
                    n_state = S_PIVOT;
                end
            end
            S_PIVOT: begin
                n_pivot = m_rdata;
                n_bnd   = lo_a;
                n_scan  = lo_a;
                n_state = (lo_a == hi_a) ? S_FIN_RD : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                m_raddr = r_scan;
                n_state = S_CMP;
            end
            S_CMP: begin
                n_sval = m_rdata;
                if (less && (r_bnd != r_scan)) begin
                    m_raddr = r_bnd;
                    n_state = S_SWAP1;
                end else begin
                    if (less) begin
                        n_bnd = r_bnd + 1'b1;
                    end
                    n_scan  = scan_nxt;
                    n_state = scan_end ? S_FIN_RD : S_SCAN_RD;
                end
            end
            S_SWAP1: begin
                m_we    = 1'b1;
                m_waddr = r_scan;
                m_wdata = m_rdata;
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                m_we    = 1'b1;
                m_waddr = r_bnd;
                m_wdata = r_sval;
                n_bnd   = r_bnd + 1'b1;
                n_scan  = scan_nxt;
                n_state = scan_end ? S_FIN_RD : S_SCAN_RD;
            end
            S_FIN_RD: begin
                m_raddr = r_bnd;
                n_state = S_FIN1;
            end
            S_FIN1: begin
                // pivot slot was never touched during the scan
                m_we    = 1'b1;
                m_waddr = hi_a;
                m_wdata = m_rdata;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                m_we    = 1'b1;
                m_waddr = r_bnd;
                m_wdata = r_pivot;
                n_piv   = r_bnd;
                n_state = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                if (!r_ovalid || o_out.ready) begin
                    m_raddr = r_k;
                    n_state = S_EMIT_OUT;
                end
            end
            S_EMIT_OUT: begin
                n_ovalid = 1'b1;
                n_oindex = k_x[OUT_IDX_W-1:0];
                n_oelem  = rd_ext[VALUE_W-1:0];
                n_opiv   = piv_x[OUT_IDX_W-1:0];
                n_obad   = r_bad;
                n_ofinal = emit_last;
                if (emit_last) begin
                    n_count = '0;
                    n_state = S_LOAD;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.index       = r_oindex;
    assign o_out.element     = r_oelem;
    assign o_out.pivot_index = r_opiv;
    assign o_out.bad_range   = r_obad;
    assign o_out.final_res   = r_ofinal;

`ifndef SYNTHESIS
    a_ovalid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_EMIT_OUT))
        else $error("output valid rose outside the emit step");

    a_bad_piv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_obad) |-> (r_opiv == '0))
        else $error("bad range with nonzero pivot index");

    a_bnd_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_bnd <= r_scan))
        else $error("partition boundary passed scan index");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_OUT && emit_last) |=> (r_state == S_LOAD && r_count == '0))
        else $error("run did not end after final transfer was staged");
`endif

endmodule

// ===== bench/lpe_checker.sv =====
`timescale 1ns / 100ps

module lpe_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    lpe_in_if    i_mon_in,
    lpe_out_if   i_mon_out,
    output int   o_errors,
    output int   o_pending,
    output int   o_runs,
    output int   o_bad_runs,
    output int   o_results,
    output int   o_dropped
);
    import lpe_pkg::*;

    localparam int STORE_DEPTH = DEPTH_DEF;

    typedef struct {
        logic        [OUT_IDX_W-1:0] index;
        logic signed [VALUE_W-1:0]   element;
        logic        [OUT_IDX_W-1:0] pivot_index;
        logic                        bad_range;
        logic                        final_res;
    } t_emit_rec;

    logic signed [VALUE_W-1:0] held_elems [STORE_DEPTH];
    int                        held_count;
    t_emit_rec                 emit_queue [$];

    // Lomuto pass over the held run, then queue one emitted word per entry.
    function automatic void predict_partition(input logic [RANGE_W-1:0] lo,
                                              input logic [RANGE_W-1:0] hi);
        int                        lo_i;
        int                        hi_i;
        int                        bound;
        int                        piv;
        bit                        bad;
        logic signed [VALUE_W-1:0] pv;
        logic signed [VALUE_W-1:0] tmp;
        t_emit_rec                 rec;
        lo_i  = int'(lo);
        hi_i  = int'(hi);
        piv   = 0;
        bad   = (lo_i > hi_i) || (hi_i >= held_count);
        if (!bad) begin
            pv    = held_elems[hi_i];
            bound = lo_i;
            for (int k = lo_i; k < hi_i; k++) begin
                if (held_elems[k] < pv) begin
                    tmp               = held_elems[bound];
                    held_elems[bound] = held_elems[k];
                    held_elems[k]     = tmp;
                    bound++;
                end
            end
            tmp               = held_elems[bound];
            held_elems[bound] = held_elems[hi_i];
            held_elems[hi_i]  = tmp;
            piv               = bound;
        end
        for (int k = 0; k < held_count; k++) begin
            rec.index       = OUT_IDX_W'(k);
            rec.element     = held_elems[k];
            rec.pivot_index = OUT_IDX_W'(piv);
            rec.bad_range   = bad;
            rec.final_res   = (k == held_count - 1);
            emit_queue      = {emit_queue, rec};
        end
        held_count = 0;
        o_runs++;
        if (bad) o_bad_runs++;
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint act_v);
        if (exp_v != act_v) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_emit_rec rec;
        if (!i_rst_n) begin
            held_count = 0;
        end else begin
            if (i_mon_in.valid && i_mon_in.ready) begin
                // store full: further words of the run are dropped
                if (held_count < STORE_DEPTH) begin
                    held_elems[held_count] = i_mon_in.value;
                    held_count++;
                end else begin
                    o_dropped++;
                end
                if (i_mon_in.last)
                    predict_partition(i_mon_in.range_low, i_mon_in.range_high);
            end
            if (i_mon_out.valid && i_mon_out.ready) begin
                o_results++;
                if (emit_queue.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected transfer, expected none, actual index %0d element %0d",
                             $time, i_mon_out.index, i_mon_out.element);
                end else begin
                    rec = emit_queue.pop_front();
                    check_field("index", rec.index, i_mon_out.index);
                    check_field("element", rec.element, i_mon_out.element);
                    check_field("pivot_index", rec.pivot_index, i_mon_out.pivot_index);
                    check_field("bad_range", rec.bad_range, i_mon_out.bad_range);
                    check_field("final_res", rec.final_res, i_mon_out.final_res);
                end
            end
        end
        o_pending = emit_queue.size();
    end

endmodule

// ===== bench/tb_lomuto_partition_engine.sv =====
`timescale 1ns / 100ps

module tb_lomuto_partition_engine;
    import lpe_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 170;

    logic i_clk;
    logic i_rst_n;

    lpe_in_if  in_if ();
    lpe_out_if out_if ();

    int errors;
    int pending;
    int runs;
    int bad_runs;
    int results;
    int dropped;

    bit gaps_on;
    int hold_requests;
    int items_sent;
    int cycle_count;

    logic signed [VALUE_W-1:0] run_vals [$];

    lomuto_partition_engine DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    lpe_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mon_in   (in_if),
        .i_mon_out  (out_if),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_runs     (runs),
        .o_bad_runs (bad_runs),
        .o_results  (results),
        .o_dropped  (dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still pending", cycle_count, pending);
        $display("Verification failed");
        $finish;
    end

    // result side: random stalls, or a long hold-off when requested
    initial begin
        int hold_left;
        int served;
        hold_left    = 0;
        served       = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (gaps_on) begin
                out_if.ready <= ($urandom_range(0, 99) >= 21);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic signed [VALUE_W-1:0] val, input logic is_last,
                             input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi);
        @(negedge i_clk);
        while (gaps_on && $urandom_range(0, 99) < 21) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.value      <= val;
        in_if.last       <= is_last;
        in_if.range_low  <= lo;
        in_if.range_high <= hi;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    // range fields of non-final words are don't-care, so they carry noise
    task automatic send_run(input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi);
        for (int k = 0; k < run_vals.size(); k++) begin
            if (k == run_vals.size() - 1)
                send_item(run_vals[k], 1'b1, lo, hi);
            else
                send_item(run_vals[k], 1'b0, RANGE_W'($urandom_range(0, 31)),
                          RANGE_W'($urandom_range(0, 31)));
        end
    endtask

    // the last transfer leaves valid high, so drop it before idling
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] rand_elem();
        int pick;
        pick = $urandom_range(0, 11);
        if (pick < 4) return $urandom_range(0, 8) - 4;   // duplicates and ties
        if (pick == 4) return 32'h7FFF_FFFF;
        if (pick == 5) return 32'h8000_0000;
        return $urandom;
    endfunction

    // mostly valid bounds; the rest low above high or high past the count
    task automatic rand_run();
        int                 len;
        int                 cnt;
        int                 pick;
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(32, 35) : $urandom_range(1, 12);
        cnt = (len > 32) ? 32 : len;
        run_vals.delete();
        for (int k = 0; k < len; k++) run_vals = {run_vals, rand_elem()};
        pick = $urandom_range(0, 99);
        if (pick < 72) begin
            hi = RANGE_W'($urandom_range(0, cnt - 1));
            lo = RANGE_W'($urandom_range(0, hi));
        end else if (pick < 86 && cnt < 32) begin
            hi = RANGE_W'($urandom_range(cnt, 31));
            lo = RANGE_W'($urandom_range(0, 31));
        end else begin
            lo = RANGE_W'($urandom_range(1, 31));
            hi = RANGE_W'($urandom_range(0, lo - 1));
        end
        send_run(lo, hi);
    endtask

    initial begin
        int rand_start;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.value      = '0;
        in_if.last       = 1'b0;
        in_if.range_low  = '0;
        in_if.range_high = '0;
        gaps_on          = 1'b1;
        hold_requests    = 0;
        items_sent       = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-element range at the most negative value
        run_vals = '{32'h8000_0000};
        send_run(0, 0);
        // extremes around a zero pivot
        run_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 0};
        send_run(0, 2);
        // words equal to the pivot stay behind the boundary
        run_vals = '{5, -1, 5, 5};
        send_run(0, 3);
        // subrange inside the run
        run_vals = '{7, 3, 9, 1, -8};
        send_run(1, 3);
        // low above high
        run_vals = '{1, 2};
        send_run(1, 0);
        // high past the count
        run_vals = '{3, 4};
        send_run(0, 5);
        // all-ones bounds, invalid for a short run
        run_vals = '{-2, 6, 0};
        send_run(31, 31);

        // long result hold-off: the next run backs up behind the stalled emit
        wait_drained();
        hold_requests++;
        for (int n = 0; n < 2; n++) rand_run();

        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            gaps_on = !((items_sent - rand_start) >= 80 && (items_sent - rand_start) < 130);
            if ((items_sent - rand_start) > 140 && (items_sent - rand_start) < 155)
                wait_drained();
            rand_run();
        end
        gaps_on = 1'b1;

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d partitions (%0d with invalid bounds) over %0d input words,",
                 runs, bad_runs, items_sent);
        $display("%0d results checked, %0d words past a full store", results, dropped);
        if (errors == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
